// File: rtl/core/pwdd_pkg.sv
package pwdd_pkg;

  localparam int NUM_STAGES = 7;

  localparam logic [15:0] EPOCH_MJD = 16'd51604;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [15:0] DAYS_4Y   = 16'd1461;
  localparam logic [10:0] DAYS_1Y   = 11'd365;
  localparam logic [11:0] BASE_YEAR = 12'd2000;

  // ceil(2^26 / 1461), exact for every remainder below one century
  localparam logic [31:0] RECIP_4Y    = 32'd45934;
  localparam int          RECIP_SHIFT = 26;

  // months counted from march, q15 and q5 fixed point
  localparam logic [19:0] MON_MUL   = 20'd1071;
  localparam logic [19:0] MON_RND   = 20'd450;
  localparam int          MON_SHIFT = 15;
  localparam logic [13:0] DOM_MUL   = 14'd979;
  localparam logic [13:0] DOM_RND   = 14'd16;
  localparam int          DOM_SHIFT = 5;

  typedef struct packed {
    logic [7:0]  group_id;
    logic [7:0]  hold_hours;
    logic [15:0] net_ident;
    logic [15:0] ts_ident;
  } pass_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

endpackage

// File: rtl/core/power_on_window_date_decoder.sv
// Power-on window date decoder.
// Input channel: one control record per request (group_id, ref_date_mjd,
// backoff_days, window_days, hold_hours, net_ident, ts_ident) under
// in_valid / in_stall. Output channel: start and limit dates as year,
// month and day, plus the copied identifiers, under out_valid / out_stall.
// start = ref_date_mjd - backoff_days, limit = start + window_days - 1,
// both taken modulo 65536 days from 1 march 2000.
// Each request gives exactly one result. The pipeline has seven register
// stages (offset, century, four-year reciprocal multiply, four-year
// remainder, year split, month multiply, day and calendar fix-up) and
// takes one request every cycle while the output is not stalled.
// A stall on the output holds the last stage; earlier stages keep moving
// until they reach a full stage, so bubbles close up and in_stall only
// rises once every stage holds a request.
// Reset (rst, synchronous) clears every valid bit; the pipeline is empty
// and ready in the cycle after reset falls.
module power_on_window_date_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  group_id,
  input  logic [15:0] ref_date_mjd,
  input  logic [7:0]  backoff_days,
  input  logic [7:0]  window_days,
  input  logic [7:0]  hold_hours,
  input  logic [15:0] net_ident,
  input  logic [15:0] ts_ident,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] start_year,
  output logic [3:0]  start_month,
  output logic [4:0]  start_day,
  output logic [11:0] limit_year,
  output logic [3:0]  limit_month,
  output logic [4:0]  limit_day,
  output logic [7:0]  group_out,
  output logic [7:0]  hold_out,
  output logic [15:0] net_out,
  output logic [15:0] ts_out
);
  import pwdd_pkg::*;

  // lane 0 is the start date, lane 1 the limit date
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] rdy;
  pass_t pt [1:NUM_STAGES];

  logic [15:0] u1 [2];
  logic        c100_2 [2];
  logic [15:0] r100_2 [2];
  logic        c100_3 [2];
  logic [15:0] r100_3 [2];
  logic [31:0] prod3 [2];
  logic [10:0] r4_4 [2];
  logic [7:0]  yp4 [2];
  logic [8:0]  r1_5 [2];
  logic [7:0]  yp5 [2];
  logic [8:0]  r1_6 [2];
  logic [7:0]  yp6 [2];
  logic [3:0]  mon6 [2];
  date_t       dt7 [2];

  logic [15:0] u1_next [2];
  logic        c100_2_next [2];
  logic [15:0] r100_2_next [2];
  logic [4:0]  c4 [2];
  logic [10:0] r4_4_next [2];
  logic [7:0]  yp4_next [2];
  logic [1:0]  c1 [2];
  logic [8:0]  r1_5_next [2];
  logic [7:0]  yp5_next [2];
  logic [3:0]  mon6_next [2];
  logic        ywrap [2];
  date_t       dt7_next [2];

  always_comb begin
    rdy[NUM_STAGES] = !v[NUM_STAGES] || !out_stall;
    for (int i = NUM_STAGES - 1; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[1];

  always_comb begin
    // offset from the epoch; a negative offset wraps by 65536, which the
    // 16-bit arithmetic gives for free
    u1_next[0] = ref_date_mjd - {8'd0, backoff_days} - EPOCH_MJD;
    u1_next[1] = u1_next[0] + {8'd0, window_days} - 16'd1;
    for (int k = 0; k < 2; k++) begin
      // offsets stay below one 400-year cycle and below two centuries
      c100_2_next[k] = (u1[k] >= DAYS_100Y);
      r100_2_next[k] = c100_2_next[k] ? (u1[k] - DAYS_100Y) : u1[k];

      c4[k]        = prod3[k][RECIP_SHIFT +: 5];
      r4_4_next[k] = 11'(r100_3[k] - 16'(c4[k]) * DAYS_4Y);
      yp4_next[k]  = (c100_3[k] ? 8'd100 : 8'd0) + {1'b0, c4[k], 2'b00};

      // the last day of a four-year cycle clamps to three, landing on 29 february
      priority if (r4_4[k] >= 11'(3 * DAYS_1Y)) c1[k] = 2'd3;
      else if (r4_4[k] >= 11'(2 * DAYS_1Y))     c1[k] = 2'd2;
      else if (r4_4[k] >= DAYS_1Y)              c1[k] = 2'd1;
      else                                      c1[k] = 2'd0;
      r1_5_next[k] = 9'(r4_4[k] - 11'(c1[k]) * DAYS_1Y);
      yp5_next[k]  = yp4[k] + 8'(c1[k]);

      mon6_next[k] = 4'((20'(r1_5[k]) * MON_MUL + MON_RND) >> MON_SHIFT);

      ywrap[k]          = (mon6[k] >= 4'd10);
      dt7_next[k].month = ywrap[k] ? (mon6[k] - 4'd9) : (mon6[k] + 4'd3);
      dt7_next[k].year  = BASE_YEAR + 12'(yp6[k]) + 12'(ywrap[k]);
      dt7_next[k].day   = 5'(r1_6[k]
                          - 9'((14'(mon6[k]) * DOM_MUL + DOM_RND) >> DOM_SHIFT)
                          + 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = NUM_STAGES; i >= 2; i--) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
      if (rdy[1]) v[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pt[1] <= '{group_id: group_id, hold_hours: hold_hours,
                 net_ident: net_ident, ts_ident: ts_ident};
      u1    <= u1_next;
    end
    for (int i = 2; i <= NUM_STAGES; i++) begin
      if (rdy[i]) pt[i] <= pt[i-1];
    end
    for (int k = 0; k < 2; k++) begin
      if (rdy[2]) begin
        c100_2[k] <= c100_2_next[k];
        r100_2[k] <= r100_2_next[k];
      end
      if (rdy[3]) begin
        c100_3[k] <= c100_2[k];
        r100_3[k] <= r100_2[k];
        prod3[k]  <= 32'(r100_2[k]) * RECIP_4Y;
      end
      if (rdy[4]) begin
        r4_4[k] <= r4_4_next[k];
        yp4[k]  <= yp4_next[k];
      end
      if (rdy[5]) begin
        r1_5[k] <= r1_5_next[k];
        yp5[k]  <= yp5_next[k];
      end
      if (rdy[6]) begin
        r1_6[k] <= r1_5[k];
        yp6[k]  <= yp5[k];
        mon6[k] <= mon6_next[k];
      end
      if (rdy[7]) begin
        dt7[k] <= dt7_next[k];
      end
    end
  end

  assign out_valid   = v[NUM_STAGES];
  assign start_year  = dt7[0].year;
  assign start_month = dt7[0].month;
  assign start_day   = dt7[0].day;
  assign limit_year  = dt7[1].year;
  assign limit_month = dt7[1].month;
  assign limit_day   = dt7[1].day;
  assign group_out   = pt[NUM_STAGES].group_id;
  assign hold_out    = pt[NUM_STAGES].hold_hours;
  assign net_out     = pt[NUM_STAGES].net_ident;
  assign ts_out      = pt[NUM_STAGES].ts_ident;

  a_empty_first_stage_takes: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (start_month >= 4'd1 && start_month <= 4'd12 &&
                   limit_month >= 4'd1 && limit_month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (start_day != 5'd0 && limit_day != 5'd0))
    else $error("day of month is zero");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (start_year >= BASE_YEAR && start_year <= 12'd2180 &&
                   limit_year >= BASE_YEAR && limit_year <= 12'd2180))
    else $error("year out of range");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// File: tb/power_on_window_date_decoder_test.sv
`timescale 1ns / 1ps

module power_on_window_date_decoder_test;
  import pwdd_pkg::*;

  localparam int MJD_EPOCH    = 51604;
  localparam int WRAP_SPAN    = 65536;
  localparam int QUAD_CENTURY = 146097;
  localparam int CENTURY_DAYS = 36524;
  localparam int LEAP_CYCLE   = 1461;
  localparam int YEAR_DAYS    = 365;
  localparam int FIRST_YEAR   = 2000;
  localparam int RANDOM_REQS  = 800;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  group_id;
    logic [15:0] ref_mjd;
    logic [7:0]  backoff;
    logic [7:0]  window;
    logic [7:0]  hold;
    logic [15:0] net;
    logic [15:0] ts;
  } req_t;

  typedef struct packed {
    date_t start_d;
    date_t limit_d;
    pass_t ids;
  } res_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    date_t start_d;
    date_t limit_d;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  group_id = '0;
  logic [15:0] ref_date_mjd = '0;
  logic [7:0]  backoff_days = '0;
  logic [7:0]  window_days = '0;
  logic [7:0]  hold_hours = '0;
  logic [15:0] net_ident = '0;
  logic [15:0] ts_ident = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_day;
  logic [11:0] limit_year;
  logic [3:0]  limit_month;
  logic [4:0]  limit_day;
  logic [7:0]  group_out;
  logic [7:0]  hold_out;
  logic [15:0] net_out;
  logic [15:0] ts_out;

  res_t pending_dates[$];
  res_t drv_dates = '0;
  res_t got_dates;
  res_t want_dates;
  int   accepted = 0;
  int   delivered = 0;
  int   mismatches = 0;
  int   send_max = 5;
  int   recv_max = 5;

  power_on_window_date_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .group_id     (group_id),
    .ref_date_mjd (ref_date_mjd),
    .backoff_days (backoff_days),
    .window_days  (window_days),
    .hold_hours   (hold_hours),
    .net_ident    (net_ident),
    .ts_ident     (ts_ident),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .limit_year   (limit_year),
    .limit_month  (limit_month),
    .limit_day    (limit_day),
    .group_out    (group_out),
    .hold_out     (hold_out),
    .net_out      (net_out),
    .ts_out       (ts_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // signed MJD day number to calendar date; the offset from 1 march 2000 wraps by 65536
  function automatic date_t day_to_calendar(int day);
    date_t d;
    int off, rem, c400, c100, c4, c1, mon, dom, yr;
    off = day - MJD_EPOCH;
    if (off < 0) off += WRAP_SPAN;
    c400 = off / QUAD_CENTURY;
    rem  = off % QUAD_CENTURY;
    c100 = rem / CENTURY_DAYS;
    rem  = rem - c100 * CENTURY_DAYS;
    c4   = rem / LEAP_CYCLE;
    rem  = rem - c4 * LEAP_CYCLE;
    c1   = rem / YEAR_DAYS;
    // last day of a four-year cycle lands on 29 february
    if (c1 > 3) c1 = 3;
    rem  = rem - c1 * YEAR_DAYS;
    mon  = (1071 * rem + 450) >>> 15;
    dom  = rem - ((979 * mon + 16) >>> 5);
    yr   = c400 * 400 + c100 * 100 + c4 * 4 + c1 + FIRST_YEAR;
    mon  = mon + 3;
    if (mon > 12) begin
      mon = mon - 12;
      yr  = yr + 1;
    end
    d.year  = yr[11:0];
    d.month = mon[3:0];
    d.day   = dom[4:0] + 5'd1;
    return d;
  endfunction

  function automatic res_t window_dates(req_t r);
    res_t e;
    int first_day;
    first_day = int'(r.ref_mjd) - int'(r.backoff);
    e.start_d = day_to_calendar(first_day);
    e.limit_d = day_to_calendar(first_day + int'(r.window) - 1);
    e.ids = '{r.group_id, r.hold, r.net, r.ts};
    return e;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                delivered, name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_dates.push_back(drv_dates);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        delivered++;
        got_dates = '{'{start_year, start_month, start_day},
                      '{limit_year, limit_month, limit_day},
                      '{group_out, hold_out, net_out, ts_out}};
        if (pending_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting", delivered));
        end else begin
          want_dates = pending_dates.pop_front();
          if (^got_dates === 1'bx)
            report_mismatch($sformatf("result %0d carries unknown bits", delivered));
          check_field("start_year",  int'(got_dates.start_d.year),
                      int'(want_dates.start_d.year));
          check_field("start_month", int'(got_dates.start_d.month),
                      int'(want_dates.start_d.month));
          check_field("start_day",   int'(got_dates.start_d.day),
                      int'(want_dates.start_d.day));
          check_field("limit_year",  int'(got_dates.limit_d.year),
                      int'(want_dates.limit_d.year));
          check_field("limit_month", int'(got_dates.limit_d.month),
                      int'(want_dates.limit_d.month));
          check_field("limit_day",   int'(got_dates.limit_d.day),
                      int'(want_dates.limit_d.day));
          check_field("group_out",   int'(got_dates.ids.group_id),
                      int'(want_dates.ids.group_id));
          check_field("hold_out",    int'(got_dates.ids.hold_hours),
                      int'(want_dates.ids.hold_hours));
          check_field("net_out",     int'(got_dates.ids.net_ident),
                      int'(want_dates.ids.net_ident));
          check_field("ts_out",      int'(got_dates.ids.ts_ident),
                      int'(want_dates.ids.ts_ident));
        end
      end
    end
  end

  // receiver: hold off for a drawn number of cycles before each result
  initial begin
    int hold_off, seen;
    forever begin
      hold_off = $urandom_range(0, recv_max);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      seen = delivered;
      @(negedge clk);
      while (delivered == seen) @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(req_t r, res_t e);
    int gap, target;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    group_id     <= r.group_id;
    ref_date_mjd <= r.ref_mjd;
    backoff_days <= r.backoff;
    window_days  <= r.window;
    hold_hours   <= r.hold;
    net_ident    <= r.net;
    ts_ident     <= r.ts;
    drv_dates    <= e;
    target = accepted + 1;
    @(negedge clk);
    while (accepted < target) @(negedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    row_t dir_tab[$];
    req_t r;
    res_t e;
    int   n, off;

    // extremes of every field
    dir_tab.push_back('{'{8'h00, 16'd0, 8'd0, 8'd0, 8'h00, 16'h0000, 16'h0000},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'hff, 16'd0, 8'd255, 8'd255, 8'hff, 16'hffff, 16'hffff},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h01, 16'd65535, 8'd0, 8'd255, 8'h80, 16'h0001, 16'h8000},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h80, 16'd65535, 8'd255, 8'd0, 8'h01, 16'h8000, 16'h0001},
                        1'b0, '0, '0});
    // epoch itself, one-day and two-day windows
    dir_tab.push_back('{'{8'h12, 16'd51604, 8'd0, 8'd1, 8'h34, 16'h1234, 16'h5678},
                        1'b1, '{12'd2000, 4'd3, 5'd1}, '{12'd2000, 4'd3, 5'd1}});
    dir_tab.push_back('{'{8'h21, 16'd51604, 8'd0, 8'd2, 8'h43, 16'h4321, 16'h8765},
                        1'b1, '{12'd2000, 4'd3, 5'd1}, '{12'd2000, 4'd3, 5'd2}});
    // day before the epoch wraps forward
    dir_tab.push_back('{'{8'h03, 16'd51603, 8'd0, 8'd1, 8'h07, 16'h0102, 16'h0304},
                        1'b0, '0, '0});
    // back-off larger than the reference
    dir_tab.push_back('{'{8'h04, 16'd100, 8'd200, 8'd10, 8'h08, 16'h0506, 16'h0708},
                        1'b0, '0, '0});
    // zero window puts the limit one day before the start
    dir_tab.push_back('{'{8'h05, 16'd60000, 8'd5, 8'd0, 8'h09, 16'h090a, 16'h0b0c},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h06, 16'd51969, 8'd0, 8'd1, 8'h0a, 16'h0d0e, 16'h0f10},
                        1'b1, '{12'd2001, 4'd3, 5'd1}, '{12'd2001, 4'd3, 5'd1}});
    // leap day at the end of the first four-year cycle
    dir_tab.push_back('{'{8'h07, 16'd53064, 8'd0, 8'd1, 8'h0b, 16'h1112, 16'h1314},
                        1'b1, '{12'd2004, 4'd2, 5'd29}, '{12'd2004, 4'd2, 5'd29}});
    dir_tab.push_back('{'{8'h08, 16'd53065, 8'd1, 8'd2, 8'h0c, 16'h1516, 16'h1718},
                        1'b1, '{12'd2004, 4'd2, 5'd29}, '{12'd2004, 4'd3, 5'd1}});
    // 2100 is not a leap year: 28 february then 1 march
    dir_tab.push_back('{'{8'h09, 16'd22591, 8'd0, 8'd2, 8'h0d, 16'h191a, 16'h1b1c},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h0a, 16'd51700, 8'd200, 8'd255, 8'h0e, 16'h1d1e, 16'h1f20},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'haa, 16'haaaa, 8'h55, 8'haa, 8'h55, 16'h5555, 16'haaaa},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h55, 16'h5555, 8'haa, 8'h55, 8'haa, 16'haaaa, 16'h5555},
                        1'b0, '0, '0});
    dir_tab.push_back('{'{8'h0b, 16'd51603, 8'd255, 8'd255, 8'h0f, 16'h2122, 16'h2324},
                        1'b0, '0, '0});

    wait (!rst);
    @(negedge clk);

    foreach (dir_tab[i]) begin
      r = dir_tab[i].req;
      if (dir_tab[i].typed)
        e = '{dir_tab[i].start_d, dir_tab[i].limit_d, '{r.group_id, r.hold, r.net, r.ts}};
      else
        e = window_dates(r);
      send_request(r, e);
    end
    drain_pipeline();

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) begin
        case (n)
          0:   begin send_max = 0;  recv_max = 17; end
          100: begin send_max = 0;  recv_max = 0;  end
          default: begin
            send_max = (n % 200 == 0) ? 17 : $urandom_range(0, 2) * 8;
            recv_max = $urandom_range(0, 2) * 8;
          end
        endcase
      end
      if (n == RANDOM_REQS / 2) drain_pipeline();
      r.group_id = 8'($urandom_range(0, 255));
      r.hold     = 8'($urandom_range(0, 255));
      r.net      = 16'($urandom_range(0, 65535));
      r.ts       = 16'($urandom_range(0, 65535));
      r.backoff  = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
      r.window   = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: r.ref_mjd = 16'($urandom_range(0, 65535));
        1: r.ref_mjd = $urandom_range(0, 1) ? 16'($urandom_range(0, 511))
                                             : 16'($urandom_range(65024, 65535));
        2: r.ref_mjd = 16'(MJD_EPOCH - 300 + $urandom_range(0, 600));
        default: begin
          // near year and leap-cycle boundaries
          off = $urandom_range(0, 44) * LEAP_CYCLE + $urandom_range(0, 3) * YEAR_DAYS
                + $urandom_range(0, 400) - 200;
          r.ref_mjd = 16'((off + MJD_EPOCH) % WRAP_SPAN);
        end
      endcase
      send_request(r, window_dates(r));
    end

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: power_on_window_date_decoder.f
rtl/core/pwdd_pkg.sv
rtl/core/power_on_window_date_decoder.sv
tb/power_on_window_date_decoder_test.sv
